/* rtl/core/three_channel_sound_generator_core_defines.svh */
// Assertion macros for the three-channel sound generator core.
// Clocked on clk_i and disabled while rst_ni is low in the including module.
`ifndef THREE_CHANNEL_SOUND_GENERATOR_CORE_DEFINES_SVH
`define THREE_CHANNEL_SOUND_GENERATOR_CORE_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define TSG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle that forces a consequence in the next.
`define TSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/tsg_pkg.sv */
// Package of the three-channel sound generator: command codes, register map,
// envelope shape bits, amplitude table and the structs passed between modules.
// No dependencies.
`default_nettype none

package tsg_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  localparam logic [3:0] REG_TONE_A_FINE   = 4'd0;
  localparam logic [3:0] REG_TONE_A_COARSE = 4'd1;
  localparam logic [3:0] REG_TONE_B_FINE   = 4'd2;
  localparam logic [3:0] REG_TONE_B_COARSE = 4'd3;
  localparam logic [3:0] REG_TONE_C_FINE   = 4'd4;
  localparam logic [3:0] REG_TONE_C_COARSE = 4'd5;
  localparam logic [3:0] REG_NOISE_PERIOD  = 4'd6;
  localparam logic [3:0] REG_MIXER         = 4'd7;
  localparam logic [3:0] REG_AMP_A         = 4'd8;
  localparam logic [3:0] REG_AMP_B         = 4'd9;
  localparam logic [3:0] REG_AMP_C         = 4'd10;
  localparam logic [3:0] REG_ENV_FINE      = 4'd11;
  localparam logic [3:0] REG_ENV_COARSE    = 4'd12;
  localparam logic [3:0] REG_ENV_SHAPE     = 4'd13;

  localparam int unsigned SHAPE_HOLD   = 0;
  localparam int unsigned SHAPE_ALT    = 1;
  localparam int unsigned SHAPE_ATTACK = 2;
  localparam int unsigned SHAPE_CONT   = 3;
  localparam int unsigned STEP_DECAY   = 4;
  localparam int unsigned NOISE_BIT    = 3;

  localparam logic [7:0]  MIXER_RESET     = 8'h3F;
  localparam logic [16:0] NOISE_TAP_HIGH  = 17'h02000;
  localparam logic [16:0] NOISE_TAP_LOW   = 17'h10000;

  localparam logic [5:0] AMP_TABLE [16] = '{
    6'd0, 6'd1, 6'd3, 6'd5, 6'd7, 6'd9, 6'd12, 6'd14,
    6'd17, 6'd20, 6'd23, 6'd26, 6'd30, 6'd34, 6'd38, 6'd42
  };

  typedef struct packed {
    logic       valid;
    logic [1:0] command;
    logic [7:0] address;
    logic [7:0] write_data;
  } tsg_op_t;

  typedef struct packed {
    logic [5:0]      mixer;
    logic [2:0][4:0] amp_reg;
    logic [3:0]      out_bits;
    logic [3:0]      env_level;
  } tsg_mix_src_t;

endpackage

`default_nettype wire

/* rtl/core/tsg_in_if.sv */
// Input channel of the sound generator: command, address and write byte.
// No dependencies.
`default_nettype none

interface tsg_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] address;
  logic [7:0] write_data;

  modport source (output valid, output command, output address, output write_data,
                  input ready);
  modport sink (input valid, input command, input address, input write_data,
                output ready);
endinterface

`default_nettype wire

/* rtl/core/tsg_out_if.sv */
// Result channel of the sound generator: read byte and signed sample.
// No dependencies.
`default_nettype none

interface tsg_out_if;
  logic              valid;
  logic              ready;
  logic [7:0]        read_data;
  logic signed [7:0] sample;

  modport source (output valid, output read_data, output sample, input ready);
  modport sink (input valid, input read_data, input sample, output ready);
endinterface

`default_nettype wire

/* rtl/core/tsg_gen.sv */
// Generator state of the sound generator: register file, tone, noise and
// envelope dividers, updated once per operation. Depends on tsg_pkg.
`default_nettype none

module tsg_gen import tsg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  tsg_op_t      op_i,
  output logic [7:0]   read_data_o,
  output tsg_mix_src_t mix_src_o
);

  logic [7:0]  regs_q [16];
  logic [7:0]  regs_d [16];
  logic [15:0] tone_cnt_q [3];
  logic [15:0] tone_cnt_d [3];
  logic [7:0]  noise_cnt_q, noise_cnt_d;
  logic [16:0] noise_shift_q, noise_shift_d;
  logic [3:0]  out_bits_q, out_bits_d;
  logic [15:0] env_cnt_q, env_cnt_d;
  logic [7:0]  env_step_q, env_step_d;
  logic [3:0]  env_level_q, env_level_d;

  logic        sel;
  logic [3:0]  reg_idx;
  logic        do_write, do_tick;
  logic [7:0]  wd;
  logic [15:0] tone_lim [3];
  logic [15:0] tone_wr_lim [3];
  logic [15:0] tone_adj [3];
  logic [15:0] noise_adj;
  logic [15:0] env_lim, env_wr_lim, env_adj;
  logic [7:0]  shape;
  logic        sticky;
  logic [7:0]  step_inc, step_new;
  logic [3:0]  step_up, step_down;
  logic        odd;
  logic        noise_out;

  function automatic logic [15:0] period_adjust(logic [15:0] cnt, logic [15:0] old_lim,
                                                logic [15:0] new_lim);
    logic signed [17:0] diff;
    diff = $signed({2'b00, old_lim}) - $signed({2'b00, cnt});
    if (old_lim == 16'd0) begin
      return 16'd0;
    end else if (diff >= $signed({2'b00, new_lim})) begin
      return 16'd0;
    end
    return cnt;
  endfunction

  assign sel      = (op_i.address[7:4] == 4'd0);
  assign reg_idx  = op_i.address[3:0];
  assign do_write = op_i.valid && (op_i.command == CMD_WRITE) && sel;
  assign do_tick  = op_i.valid && (op_i.command == CMD_TICK);
  assign shape    = regs_q[REG_ENV_SHAPE];
  assign sticky   = shape[SHAPE_HOLD] || !shape[SHAPE_CONT];

  always_comb begin
    case (reg_idx) inside
      REG_TONE_A_COARSE, REG_TONE_B_COARSE, REG_TONE_C_COARSE, REG_ENV_SHAPE: begin
        wd = {4'd0, op_i.write_data[3:0]};
      end
      REG_NOISE_PERIOD, REG_AMP_A, REG_AMP_B, REG_AMP_C: begin
        wd = {3'd0, op_i.write_data[4:0]};
      end
      default: begin
        wd = op_i.write_data;
      end
    endcase
  end

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      tone_lim[n] = {regs_q[2*n+1], regs_q[2*n]};
      if (reg_idx == 4'(2*n)) begin
        tone_wr_lim[n] = {regs_q[2*n+1], wd};
      end else begin
        tone_wr_lim[n] = {wd, regs_q[2*n]};
      end
      tone_adj[n] = period_adjust(tone_cnt_q[n], tone_lim[n], tone_wr_lim[n]);
    end
  end

  assign env_lim    = {regs_q[REG_ENV_COARSE], regs_q[REG_ENV_FINE]};
  assign env_wr_lim = (reg_idx == REG_ENV_FINE) ? {regs_q[REG_ENV_COARSE], wd}
                                                : {wd, regs_q[REG_ENV_FINE]};
  assign env_adj    = period_adjust(env_cnt_q, env_lim, env_wr_lim);
  assign noise_adj  = period_adjust({8'd0, noise_cnt_q}, {8'd0, regs_q[REG_NOISE_PERIOD]},
                                    {8'd0, wd});

  assign step_inc  = env_step_q + 8'd1;
  assign step_new  = (env_step_q[STEP_DECAY] && sticky) ? (step_inc | 8'h10) : step_inc;
  assign step_up   = step_new[3:0];
  assign step_down = ~step_new[3:0];
  assign odd       = shape[SHAPE_ALT] ^ shape[SHAPE_ATTACK];
  assign noise_out = noise_shift_q[0];

  always_comb begin
    regs_d        = regs_q;
    tone_cnt_d    = tone_cnt_q;
    noise_cnt_d   = noise_cnt_q;
    noise_shift_d = noise_shift_q;
    out_bits_d    = out_bits_q;
    env_cnt_d     = env_cnt_q;
    env_step_d    = env_step_q;
    env_level_d   = env_level_q;

    if (do_write) begin
      regs_d[reg_idx] = wd;
      for (int n = 0; n < 3; n++) begin
        if (reg_idx[3:1] == 3'(n)) begin
          tone_cnt_d[n] = tone_adj[n];
        end
      end
      if (reg_idx == REG_NOISE_PERIOD) begin
        noise_cnt_d = noise_adj[7:0];
      end
      if ((reg_idx == REG_ENV_FINE) || (reg_idx == REG_ENV_COARSE)) begin
        env_cnt_d = env_adj;
      end
      if ((reg_idx == REG_ENV_SHAPE) && sticky &&
          (env_step_q[STEP_DECAY] || !shape[SHAPE_ATTACK])) begin
        env_step_d = 8'd0;
      end
    end

    if (do_tick) begin
      for (int n = 0; n < 3; n++) begin
        if (tone_cnt_q[n] == 16'd0) begin
          tone_cnt_d[n] = tone_lim[n] - 16'd1;
          if (tone_lim[n] != 16'd0) begin
            out_bits_d[n] = ~out_bits_q[n];
          end
        end else begin
          tone_cnt_d[n] = tone_cnt_q[n] - 16'd1;
        end
      end

      if (noise_cnt_q == 8'd0) begin
        noise_cnt_d           = regs_q[REG_NOISE_PERIOD] - 8'd1;
        out_bits_d[NOISE_BIT] = noise_out;
        noise_shift_d = {1'b0, noise_shift_q[16:1]} ^
                        (noise_out ? NOISE_TAP_HIGH : NOISE_TAP_LOW);
      end else begin
        noise_cnt_d = noise_cnt_q - 8'd1;
      end

      if (env_cnt_q == 16'd0) begin
        env_cnt_d  = env_lim - 16'd1;
        env_step_d = step_new;
        if (step_new[STEP_DECAY]) begin
          if (!shape[SHAPE_CONT]) begin
            env_level_d = 4'd0;
          end else if (shape[SHAPE_HOLD]) begin
            env_level_d = odd ? 4'hF : 4'h0;
          end else begin
            env_level_d = odd ? step_up : step_down;
          end
        end else begin
          env_level_d = shape[SHAPE_ATTACK] ? step_up : step_down;
        end
      end else begin
        env_cnt_d = env_cnt_q - 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        regs_q[i] <= (4'(i) == REG_MIXER) ? MIXER_RESET : 8'd0;
      end
      for (int n = 0; n < 3; n++) begin
        tone_cnt_q[n] <= 16'd0;
      end
      noise_cnt_q   <= 8'd0;
      noise_shift_q <= 17'd0;
      out_bits_q    <= 4'hF;
      env_cnt_q     <= 16'd0;
      env_step_q    <= 8'd0;
      env_level_q   <= 4'd0;
    end else begin
      regs_q        <= regs_d;
      tone_cnt_q    <= tone_cnt_d;
      noise_cnt_q   <= noise_cnt_d;
      noise_shift_q <= noise_shift_d;
      out_bits_q    <= out_bits_d;
      env_cnt_q     <= env_cnt_d;
      env_step_q    <= env_step_d;
      env_level_q   <= env_level_d;
    end
  end

  assign read_data_o = (op_i.valid && (op_i.command == CMD_READ) && sel) ? regs_q[reg_idx]
                                                                         : 8'd0;

  assign mix_src_o.mixer      = regs_d[REG_MIXER][5:0];
  assign mix_src_o.amp_reg[0] = regs_d[REG_AMP_A][4:0];
  assign mix_src_o.amp_reg[1] = regs_d[REG_AMP_B][4:0];
  assign mix_src_o.amp_reg[2] = regs_d[REG_AMP_C][4:0];
  assign mix_src_o.out_bits   = out_bits_d;
  assign mix_src_o.env_level  = env_level_d;

endmodule

`default_nettype wire

/* rtl/core/tsg_mix.sv */
// Channel mixer of the sound generator: amplitude lookup, tone/noise gating
// and signed sum of the three channels. Depends on tsg_pkg.
`default_nettype none

module tsg_mix import tsg_pkg::*; (
  input  tsg_mix_src_t      src_i,
  output logic signed [7:0] sample_o
);

  logic              env_mode [3];
  logic [5:0]        amp [3];
  logic signed [7:0] term [3];
  logic              gate [3];
  logic signed [7:0] full_scale;

  assign full_scale = $signed({2'b00, AMP_TABLE[4'hF]});

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      env_mode[n] = src_i.amp_reg[n][4];
      amp[n]      = AMP_TABLE[env_mode[n] ? src_i.env_level : src_i.amp_reg[n][3:0]];
      gate[n]     = (src_i.mixer[n] || src_i.out_bits[n]) &&
                    (src_i.mixer[n+3] || src_i.out_bits[NOISE_BIT]);
      if (src_i.mixer[n] && src_i.mixer[n+3]) begin
        term[n] = env_mode[n] ? ($signed({1'b0, amp[n], 1'b0}) - full_scale) : 8'sd0;
      end else begin
        term[n] = gate[n] ? $signed({2'b00, amp[n]}) : -$signed({2'b00, amp[n]});
      end
    end
  end

  assign sample_o = term[0] + term[1] + term[2];

endmodule

`default_nettype wire

/* rtl/core/three_channel_sound_generator_core.sv */
// Top level of the three-channel sound generator core.
// Depends on tsg_pkg, tsg_in_if, tsg_out_if, tsg_gen, tsg_mix and the defines header.
`default_nettype none
`include "three_channel_sound_generator_core_defines.svh"

// Every transfer on in_i (tick, register read or register write) yields exactly
// one transfer on out_o, in order. A new item is taken every clock cycle while
// out_o keeps up; the item is held in the input register and its result in the
// output register that drives out_o. All state (register file, dividers, noise
// shift register, envelope) is updated in a single pass between those two
// registers. read_data carries the register on a read and is zero otherwise;
// sample carries the mix on a tick and is zero otherwise. There is no clearing
// period after reset.
module three_channel_sound_generator_core import tsg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  tsg_in_if.sink   in_i,
  tsg_out_if.source out_o
);

  logic              in_valid_q;
  logic [1:0]        command_q;
  logic [7:0]        address_q;
  logic [7:0]        write_data_q;
  logic              out_valid_q;
  logic [7:0]        read_data_q;
  logic signed [7:0] sample_q;
  logic              advance;
  tsg_op_t           op;
  tsg_mix_src_t      mix_src;
  logic [7:0]        read_data;
  logic signed [7:0] mix_sample;

  assign advance   = !out_valid_q || out_o.ready;
  assign in_i.ready = !in_valid_q || advance;

  assign op.valid      = in_valid_q && advance;
  assign op.command    = command_q;
  assign op.address    = address_q;
  assign op.write_data = write_data_q;

  tsg_gen u_gen (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .read_data_o(read_data),
    .mix_src_o  (mix_src)
  );

  tsg_mix u_mix (
    .src_i   (mix_src),
    .sample_o(mix_sample)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      command_q    <= in_i.command;
      address_q    <= in_i.address;
      write_data_q <= in_i.write_data;
    end
    if (op.valid) begin
      read_data_q <= read_data;
      sample_q    <= (command_q == CMD_TICK) ? mix_sample : 8'sd0;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = read_data_q;
  assign out_o.sample    = sample_q;

  `TSG_ASSERT_NEXT(a_item_to_result, in_valid_q && advance, out_valid_q,
                   "item left the input register without a result")
  `TSG_ASSERT_NEXT(a_result_drains, out_valid_q && out_o.ready && !in_valid_q, !out_valid_q,
                   "result repeated after transfer")
  `TSG_ASSERT(a_one_field, !(out_valid_q && (read_data_q != 8'd0) && (sample_q != 8'sd0)),
              "read data and sample both non-zero")
  `TSG_ASSERT(a_sample_range,
              !out_valid_q || ((sample_q != 8'sh80) && (sample_q != 8'sh81) &&
                               (sample_q != 8'sh7F)),
              "sample outside mix range")

endmodule

`default_nettype wire
